[rtl/pbpu_pkg.sv]
package pbpu_pkg;

    localparam int WordBits   = 32;
    localparam int Lanes      = 32;
    localparam int OffsetBits = 30;
    localparam int FillBits   = 5;

    localparam logic [2:0] MaxLog2 = 3'd5;

    typedef enum logic [2:0] {
        REG_SRC_DEPTH = 3'd0,
        REG_DST_DEPTH = 3'd1,
        REG_OFFSET    = 3'd2,
        REG_ZERO_TOO  = 3'd3,
        REG_MSB_FIRST = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [2:0]            src_log2;
        logic [2:0]            dst_log2;
        logic [OffsetBits-1:0] offset;
        logic                  zero_too;
        logic                  msb_first;
    } cfg_t;

    typedef struct packed {
        logic                widen;
        logic [2:0]          src_log2;
        logic [2:0]          dst_log2;
        logic [5:0]          dst_bits;
        logic [4:0]          src_flip;
        logic [4:0]          dst_flip;
        logic [WordBits-1:0] src_mask;
        logic [WordBits-1:0] dst_mask;
        logic [WordBits-1:0] offset;
        logic                zero_too;
        logic [4:0]          src_base;
        logic [4:0]          dst_base;
    } lane_ctl_t;

    function automatic logic [2:0] clamp_log2(input logic [2:0] v);
        logic [2:0] r;
        r = (v > MaxLog2) ? MaxLog2 : v;
        return r;
    endfunction

    function automatic logic [4:0] depth_flip(input logic [5:0] bits, input logic msb_first);
        logic [4:0] r;
        r = (msb_first && (bits < 6'd8)) ? 5'(6'd8 - bits) : 5'd0;
        return r;
    endfunction

    function automatic logic [WordBits-1:0] depth_mask(input logic [5:0] bits);
        logic [WordBits-1:0] r;
        r = {WordBits{1'b1}} >> (6'(WordBits) - bits);
        return r;
    endfunction

endpackage

[rtl/pbpu_cfg_regs.sv]
module pbpu_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [29:0]         cfg_data,
    output pbpu_pkg::cfg_t      cfg
);

    pbpu_pkg::cfg_t cfg_reg;
    pbpu_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pbpu_pkg::REG_SRC_DEPTH: cfg_next.src_log2  = cfg_data[2:0];
                pbpu_pkg::REG_DST_DEPTH: cfg_next.dst_log2  = cfg_data[2:0];
                pbpu_pkg::REG_OFFSET:    cfg_next.offset    = cfg_data;
                pbpu_pkg::REG_ZERO_TOO:  cfg_next.zero_too  = cfg_data[0];
                pbpu_pkg::REG_MSB_FIRST: cfg_next.msb_first = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_log2  <= 3'd0;
            cfg_reg.dst_log2  <= 3'd3;
            cfg_reg.offset    <= '0;
            cfg_reg.zero_too  <= 1'b0;
            cfg_reg.msb_first <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/pbpu_lane.sv]
module pbpu_lane (
    input  pbpu_pkg::lane_ctl_t ctl,
    input  logic [31:0]         word,
    input  logic [4:0]          lane_idx,
    output logic [31:0]         placed
);

    logic [9:0]  src_off;
    logic [4:0]  src_pos;
    logic [31:0] px;
    logic [31:0] adj;
    logic [31:0] px_dst;
    logic [10:0] dst_full;
    logic [4:0]  dst_pos;
    logic        fit;

    always_comb begin
        src_off  = 10'(lane_idx) << ctl.src_log2;
        src_pos  = (ctl.src_base + src_off[4:0]) ^ ctl.src_flip;
        px       = (word >> src_pos) & ctl.src_mask;
        if ((px != 32'd0) || ctl.zero_too) begin
            adj = ctl.widen ? (px + ctl.offset) : (px - ctl.offset);
        end else begin
            adj = px;
        end
        px_dst   = adj & ctl.dst_mask;
        dst_full = (11'(lane_idx) << ctl.dst_log2) + 11'(ctl.dst_base);
        fit      = (src_off < 10'd32) && ((dst_full + 11'(ctl.dst_bits)) <= 11'd32);
        dst_pos  = dst_full[4:0] ^ ctl.dst_flip;
        placed   = fit ? (px_dst << dst_pos) : 32'd0;
    end

endmodule

[rtl/pbpu_core.sv]
module pbpu_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  pbpu_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,
    output logic           m_tlast
);

    logic        in_valid_reg, in_valid_next;
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic [4:0]  k_reg, k_next;
    logic [31:0] acc_reg, acc_next;
    logic [pbpu_pkg::FillBits-1:0] fill_reg, fill_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [2:0]  sl, dl, dd, nd;
    logic [5:0]  sb, db;
    logic        widen;
    logic [9:0]  k_wide;
    logic [4:0]  last_k;
    logic        final_beat;
    logic [5:0]  fill_inc;
    logic [6:0]  fill_sum;
    logic [5:0]  fill_step;
    logic        emit;
    logic        out_free, step, accept;
    logic [31:0] lane_or, beat_word;
    logic [31:0] lane_bits [pbpu_pkg::Lanes];
    pbpu_pkg::lane_ctl_t ctl;

    always_comb begin
        sl     = pbpu_pkg::clamp_log2(cfg.src_log2);
        dl     = pbpu_pkg::clamp_log2(cfg.dst_log2);
        widen  = (dl >= sl);
        dd     = widen ? (dl - sl) : 3'd0;
        nd     = widen ? 3'd0 : (sl - dl);
        sb     = 6'd1 << sl;
        db     = 6'd1 << dl;
        k_wide = 10'(k_reg) << (pbpu_pkg::MaxLog2 - dd);
        last_k = 5'((6'd1 << dd) - 6'd1);

        ctl.widen    = widen;
        ctl.src_log2 = sl;
        ctl.dst_log2 = dl;
        ctl.dst_bits = db;
        ctl.src_flip = pbpu_pkg::depth_flip(sb, cfg.msb_first);
        ctl.dst_flip = pbpu_pkg::depth_flip(db, cfg.msb_first);
        ctl.src_mask = pbpu_pkg::depth_mask(sb);
        ctl.dst_mask = pbpu_pkg::depth_mask(db);
        ctl.offset   = 32'(cfg.offset);
        ctl.zero_too = cfg.zero_too;
        ctl.src_base = widen ? k_wide[4:0] : 5'd0;
        ctl.dst_base = widen ? 5'd0 : fill_reg;
    end

    for (genvar g = 0; g < pbpu_pkg::Lanes; g++) begin : g_lane
        pbpu_lane u_lane (
            .ctl      (ctl),
            .word     (word_reg),
            .lane_idx (5'(g)),
            .placed   (lane_bits[g])
        );
    end

    always_comb begin
        lane_or = 32'd0;
        for (int i = 0; i < pbpu_pkg::Lanes; i++) begin
            lane_or = lane_or | lane_bits[i];
        end
        beat_word  = (widen ? 32'd0 : acc_reg) | lane_or;
        final_beat = widen ? (k_reg == last_k) : 1'b1;
        fill_inc   = 6'(6'd32 >> nd);
        fill_sum   = 7'(fill_reg) + 7'(fill_inc);
        fill_step  = (fill_sum > 7'd32) ? 6'd32 : fill_sum[5:0];
        emit       = widen || (fill_step == 6'd32) || (last_reg && (fill_step != 6'd0));
        out_free   = !m_valid_reg || m_tready;
        step       = in_valid_reg && out_free;
        s_tready   = !in_valid_reg || (step && final_beat);
        accept     = s_tvalid && s_tready;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        word_next     = word_reg;
        last_next     = last_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        fill_next     = fill_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (step) begin
            if (final_beat) begin
                in_valid_next = 1'b0;
            end else begin
                k_next = k_reg + 5'd1;
            end
            if (emit) begin
                m_valid_next = 1'b1;
                m_data_next  = beat_word;
                m_last_next  = last_reg && final_beat;
            end
            if (!widen) begin
                if (emit) begin
                    acc_next  = 32'd0;
                    fill_next = '0;
                end else begin
                    acc_next  = beat_word;
                    fill_next = fill_step[4:0];
                end
            end
        end
        if (accept) begin
            in_valid_next = 1'b1;
            word_next     = s_tdata;
            last_next     = s_tlast;
            k_next        = 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            k_reg        <= 5'd0;
            acc_reg      <= 32'd0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            k_reg        <= k_next;
            acc_reg      <= acc_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[rtl/pixel_bit_pack_unpack_top.sv]
// Repacks 32-bit beats of packed pixels from a source depth of 1..32 bits to a
// destination depth, adding the offset when widening and subtracting it when
// narrowing. A source beat sits in an input register while 32 pixel lanes
// build a destination word for the output register. Widening or equal depth
// gives 2^(dst_log2 - src_log2) output beats per input beat, one per cycle
// unless the output stalls, and the next input beat is taken in the cycle the
// last of them leaves the input register. Narrowing takes one input beat per
// cycle unless the output stalls and emits a word when the partial word fills
// or on tlast. Configuration is written through cfg_valid/cfg_index/cfg_data,
// always ready, and must only change while the block is idle.
module pixel_bit_pack_unpack_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] src_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] dst_word
    output logic        m_tlast
);

    pbpu_pkg::cfg_t cfg;

    pbpu_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbpu_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/pbpu_checker.sv]
module pbpu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [29:0] cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a full input stage cannot drain while the result side stalls
    a_no_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tvalid && !m_tready) |=> (!s_tready || m_tready))
        else $error("input freed while result side stalled");

endmodule

bind pixel_bit_pack_unpack_top pbpu_checker u_pbpu_checker (.*);

[tb/sv/pixel_repack_checker.sv]
`timescale 1ns / 1ps

module pixel_repack_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          words_pending
);

    typedef struct {
        logic [31:0] word;
        logic        last;
    } dst_beat_t;

    pbpu_pkg::cfg_t depth_cfg;
    logic [31:0]    pack_word;
    int unsigned    pack_fill;
    dst_beat_t      dst_words_q[$];

    initial begin
        mismatch_count = 0;
        words_pending  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic repack_word(input logic [31:0] word, input logic last);
        int unsigned sl, dl, sb, db, sflip, dflip, spos, dpos, count, k;
        logic [31:0] smask, dmask, px, offset32, out_word;
        dst_beat_t   beat;
        sl = (depth_cfg.src_log2 > 3'd5) ? 5 : depth_cfg.src_log2;
        dl = (depth_cfg.dst_log2 > 3'd5) ? 5 : depth_cfg.dst_log2;
        sb = 1 << sl;
        db = 1 << dl;
        smask = 32'hFFFF_FFFF >> (32 - sb);
        dmask = 32'hFFFF_FFFF >> (32 - db);
        sflip = (depth_cfg.msb_first && sb < 8) ? 8 - sb : 0;
        dflip = (depth_cfg.msb_first && db < 8) ? 8 - db : 0;
        offset32 = {2'b00, depth_cfg.offset};
        spos = 0;
        if (dl >= sl) begin
            count = 1 << (dl - sl);
            for (k = 0; k < count; k++) begin
                out_word = '0;
                for (dpos = 0; dpos < 32; dpos += db) begin
                    px = (word >> ((spos ^ sflip) & 31)) & smask;
                    spos += sb;
                    if (px != 0 || depth_cfg.zero_too)
                        px = px + offset32;
                    px &= dmask;
                    out_word |= px << ((dpos ^ dflip) & 31);
                end
                beat.word = out_word;
                beat.last = last && (k + 1 == count);
                dst_words_q.push_back(beat);
            end
        end else begin
            for (spos = 0; spos < 32; spos += sb) begin
                px = (word >> ((spos ^ sflip) & 31)) & smask;
                if (px != 0 || depth_cfg.zero_too)
                    px = px - offset32;
                px &= dmask;
                // drop a pixel that no longer fits; the word then counts as full
                if (pack_fill + db <= 32) begin
                    pack_word |= px << ((pack_fill ^ dflip) & 31);
                    pack_fill += db;
                end else begin
                    pack_fill = 32;
                end
            end
            if (pack_fill >= 32 || (last && pack_fill != 0)) begin
                beat.word = pack_word;
                beat.last = last;
                dst_words_q.push_back(beat);
                pack_word = '0;
                pack_fill = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        dst_beat_t exp_beat;
        if (!aresetn) begin
            depth_cfg.src_log2  = 3'd0;
            depth_cfg.dst_log2  = 3'd3;
            depth_cfg.offset    = '0;
            depth_cfg.zero_too  = 1'b0;
            depth_cfg.msb_first = 1'b0;
            pack_word = '0;
            pack_fill = 0;
            dst_words_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (dst_words_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat data=%h last=%b",
                                              m_tdata, m_tlast));
                end else begin
                    exp_beat = dst_words_q.pop_front();
                    if (m_tdata !== exp_beat.word)
                        report_mismatch($sformatf("dst_word %h, expected %h",
                                                  m_tdata, exp_beat.word));
                    if (m_tlast !== exp_beat.last)
                        report_mismatch($sformatf("dst_last %b, expected %b",
                                                  m_tlast, exp_beat.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    pbpu_pkg::REG_SRC_DEPTH: depth_cfg.src_log2  = cfg_data[2:0];
                    pbpu_pkg::REG_DST_DEPTH: depth_cfg.dst_log2  = cfg_data[2:0];
                    pbpu_pkg::REG_OFFSET:    depth_cfg.offset    = cfg_data;
                    pbpu_pkg::REG_ZERO_TOO:  depth_cfg.zero_too  = cfg_data[0];
                    pbpu_pkg::REG_MSB_FIRST: depth_cfg.msb_first = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                repack_word(s_tdata, s_tlast);
        end
        words_pending = dst_words_q.size();
    end

endmodule

[tb/sv/pixel_bit_pack_unpack_top_tb.sv]
`timescale 1ns / 1ps

module pixel_bit_pack_unpack_top_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [29:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    int          mismatch_count;
    int          words_pending;
    int          send_calm;
    int          take_calm;

    pixel_bit_pack_unpack_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    pixel_repack_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int next_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [31:0] pixel_word();
        case ($urandom_range(0, 6))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom & $urandom & $urandom;
            3: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic [31:0] word, input logic last);
        int   gap;
        logic took;
        gap = next_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
    endtask

    // hold the input until every expected word is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (words_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input pbpu_pkg::reg_index_t idx, input logic [29:0] value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    task automatic set_depths(input logic [2:0] src, input logic [2:0] dst,
                              input logic [29:0] offset, input logic zero_too,
                              input logic msb_first);
        settle();
        write_reg(pbpu_pkg::REG_SRC_DEPTH, {27'd0, src});
        write_reg(pbpu_pkg::REG_DST_DEPTH, {27'd0, dst});
        write_reg(pbpu_pkg::REG_OFFSET, offset);
        write_reg(pbpu_pkg::REG_ZERO_TOO, {29'd0, zero_too});
        write_reg(pbpu_pkg::REG_MSB_FIRST, {29'd0, msb_first});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        take_calm = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            int   stall;
            logic took;
            stall = next_gap(take_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_tvalid;
                @(posedge aclk);
            end while (!took);
        end
    end

    initial begin
        int          phase;
        int          n;
        int          run_left;
        logic [29:0] offset;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pbpu_pkg::REG_SRC_DEPTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        send_calm = 0;
        run_left  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'hA5A5_5A5A, 1'b0);

        // leave one bit pending, then widen the pixels so the second one after it is dropped
        set_depths(3'd5, 3'd0, 30'd1, 1'b0, 1'b0);
        send_beat(32'h0000_0002, 1'b0);
        set_depths(3'd5, 3'd4, 30'd1, 1'b0, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h1234_5678, 1'b1);
        send_beat(32'h0000_0001, 1'b0);

        // partial word stays across a widening stretch
        set_depths(3'd0, 3'd5, 30'h3FFF_FFFF, 1'b1, 1'b1);
        send_beat(32'h8000_0001, 1'b1);
        set_depths(3'd2, 3'd1, 30'h3FFF_FFFF, 1'b1, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h0000_0000, 1'b1);

        set_depths(3'd3, 3'd3, 30'h3FFF_FFFF, 1'b0, 1'b0);
        send_beat(32'h00FF_0180, 1'b1);
        set_depths(3'd6, 3'd7, 30'h2AAA_AAAA, 1'b0, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h0000_0000, 1'b1);
        set_depths(3'd4, 3'd2, 30'd3, 1'b0, 1'b1);
        send_beat(32'h0003_0000, 1'b0);
        send_beat(32'hF00F_0001, 1'b1);
        set_depths(3'd1, 3'd2, 30'd2, 1'b0, 1'b1);
        send_beat(32'h1B1B_E4E4, 1'b0);
        send_beat(32'h0000_0003, 1'b1);
        set_depths(3'd7, 3'd0, 30'd0, 1'b1, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'hFFFF_FFFE, 1'b0);
        send_beat(32'h0000_0000, 1'b1);

        for (phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 3))
                0: offset = '0;
                1: offset = 30'h3FFF_FFFF;
                2: offset = 30'($urandom_range(1, 15));
                default: offset = 30'($urandom);
            endcase
            set_depths(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), offset,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (n = 0; n < 25; n++) begin
                if (run_left == 0)
                    run_left = $urandom_range(1, 8);
                // a few stray last flags break up the runs
                send_beat(pixel_word(), run_left == 1 || $urandom_range(0, 19) == 0);
                run_left--;
                if ((phase == 0 && n == 12) || $urandom_range(0, 39) == 0)
                    settle();
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("pixel_bit_pack_unpack_top_tb: done, clean");
        else
            $display("pixel_bit_pack_unpack_top_tb: done, errors");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("pixel_bit_pack_unpack_top_tb: done, errors");
        $finish;
    end

endmodule

[pixel_bit_pack_unpack_top.f]
rtl/pbpu_pkg.sv
rtl/pbpu_cfg_regs.sv
rtl/pbpu_lane.sv
rtl/pbpu_core.sv
rtl/pixel_bit_pack_unpack_top.sv
rtl/pbpu_checker.sv
tb/sv/pixel_repack_checker.sv
tb/sv/pixel_bit_pack_unpack_top_tb.sv
